FILE: sv/ltt_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ltt_pkg
// Shared types, codes and the control store of the lottery ticket table.
// ----------------------------------------------------------------------------
package ltt_pkg;

	localparam int unsigned FUNC_W  = 2;
	localparam int unsigned PID_W   = 6;
	localparam int unsigned CLS_W   = 3;
	localparam int unsigned TIX_W   = 4;
	localparam int unsigned TOTAL_W = 10;
	localparam int unsigned CHG_W   = 7;

	localparam int unsigned PROCESS_COUNT = 64;

	localparam logic [TOTAL_W-1:0] TOTAL_MAX = 10'd1023;
	localparam logic [CHG_W-1:0]   CHG_MAX   = 7'd127;

	localparam logic [FUNC_W-1:0] FUNC_ADD     = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_REMOVE  = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_COMPACT = 2'd2;

	// sequencer steps
	localparam int unsigned STEP_W = 3;
	localparam logic [STEP_W-1:0] ST_CLR  = 3'd0;
	localparam logic [STEP_W-1:0] ST_IDLE = 3'd1;
	localparam logic [STEP_W-1:0] ST_DISP = 3'd2;
	localparam logic [STEP_W-1:0] ST_SCAN = 3'd3;
	localparam logic [STEP_W-1:0] ST_TSET = 3'd4;
	localparam logic [STEP_W-1:0] ST_TAIL = 3'd5;
	localparam logic [STEP_W-1:0] ST_FIN  = 3'd6;

	// jump conditions
	localparam int unsigned COND_W = 3;
	localparam logic [COND_W-1:0] C_ALWAYS   = 3'd0;
	localparam logic [COND_W-1:0] C_ACCEPT   = 3'd1;
	localparam logic [COND_W-1:0] C_KEND     = 3'd2;
	localparam logic [COND_W-1:0] C_SKIP     = 3'd3;
	localparam logic [COND_W-1:0] C_NOCMP    = 3'd4;
	localparam logic [COND_W-1:0] C_OUT_FREE = 3'd5;

	typedef struct packed {
		logic             used;
		logic [PID_W-1:0] owner;
	} slot_t;

	typedef struct packed {
		logic add;
		logic remove;
		logic compact;
	} opsel_t;

	typedef struct packed {
		logic              in_ready;
		logic              wr_zero;
		logic              rd;
		logic              eval;
		logic              k_zero;
		logic              k_dst;
		logic              cnt_clr;
		logic              load_out;
		logic              adv;
		logic [COND_W-1:0] cond;
		logic [STEP_W-1:0] target;
	} ctl_t;

	typedef struct packed {
		logic in_valid;
		logic kend;
		logic skip;
		logic nocmp;
		logic out_free;
	} stat_t;

	function automatic logic [TIX_W-1:0] tickets_of(input logic [CLS_W-1:0] cls);
		return 4'd8 - {1'b0, cls};
	endfunction

	// one control word per step: on a hit jump to target, else advance or hold
	function automatic ctl_t ucode_rom(input logic [STEP_W-1:0] step);
		ctl_t w;
		w = '0;
		unique case (step)
			ST_CLR: begin
				w.wr_zero = 1'b1;
				w.cond    = C_KEND;
				w.target  = ST_IDLE;
			end
			ST_IDLE: begin
				w.in_ready = 1'b1;
				w.k_zero   = 1'b1;
				w.cond     = C_ACCEPT;
				w.target   = ST_DISP;
			end
			ST_DISP: begin
				w.rd      = 1'b1;
				w.cnt_clr = 1'b1;
				w.adv     = 1'b1;
				w.cond    = C_SKIP;
				w.target  = ST_FIN;
			end
			ST_SCAN: begin
				w.eval   = 1'b1;
				w.rd     = 1'b1;
				w.cond   = C_KEND;
				w.target = ST_TSET;
			end
			ST_TSET: begin
				w.k_dst  = 1'b1;
				w.adv    = 1'b1;
				w.cond   = C_NOCMP;
				w.target = ST_FIN;
			end
			ST_TAIL: begin
				w.wr_zero = 1'b1;
				w.cond    = C_KEND;
				w.target  = ST_FIN;
			end
			ST_FIN: begin
				w.load_out = 1'b1;
				w.cond     = C_OUT_FREE;
				w.target   = ST_IDLE;
			end
			default: begin
				w.cond   = C_ALWAYS;
				w.target = ST_IDLE;
			end
		endcase
		return w;
	endfunction

endpackage
`default_nettype wire

FILE: sv/ltt_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ltt_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module ltt_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

FILE: sv/ltt_sequencer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ltt_sequencer
// Step counter over the control store, with conditional jumps.
// ----------------------------------------------------------------------------
module ltt_sequencer (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire ltt_pkg::stat_t stat,
	output ltt_pkg::ctl_t      ctl
);
	import ltt_pkg::*;

	logic [STEP_W-1:0] step_q;
	logic              hit;

	assign ctl = ucode_rom(step_q);

	always_comb begin
		unique case (ctl.cond)
			C_ALWAYS:   hit = 1'b1;
			C_ACCEPT:   hit = stat.in_valid;
			C_KEND:     hit = stat.kend;
			C_SKIP:     hit = stat.skip;
			C_NOCMP:    hit = stat.nocmp;
			C_OUT_FREE: hit = stat.out_free;
			default:    hit = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= ST_CLR;
		end else if (hit) begin
			step_q <= ctl.target;
		end else if (ctl.adv) begin
			step_q <= step_q + STEP_W'(1);
		end
	end

endmodule
`default_nettype wire

FILE: sv/ltt_scan.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ltt_scan
// Slot table datapath: slot RAM, scan pointer, compact pointer, change count.
// ----------------------------------------------------------------------------
module ltt_scan #(
	parameter int unsigned TICKET_SLOTS = 64
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire ltt_pkg::ctl_t                ctl,
	input  wire ltt_pkg::opsel_t              opsel,
	input  wire logic [ltt_pkg::PID_W-1:0]    pid,
	input  wire logic [ltt_pkg::TIX_W-1:0]    tix,
	output logic                              kend,
	output logic      [ltt_pkg::CHG_W-1:0]    chg
);
	import ltt_pkg::*;

	localparam int unsigned AW = $clog2(TICKET_SLOTS);
	localparam int unsigned KW = AW + 1;

	logic [KW-1:0]    k_q;
	logic [KW-1:0]    dst_q;
	logic [CHG_W-1:0] chg_q;
	logic [KW-1:0]    eval_k;
	slot_t            rd_slot;
	logic [$bits(slot_t)-1:0] rdata;
	logic             we;
	logic [AW-1:0]    waddr;
	slot_t            wdata;
	logic             below;
	logic             add_hit;
	logic             rem_hit;
	logic             occ;
	logic             mov_hit;

	ltt_ram #(
		.WIDTH ($bits(slot_t)),
		.DEPTH (TICKET_SLOTS)
	) u_slots (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (k_q[AW-1:0]),
		.rdata (rdata)
	);

	assign rd_slot = slot_t'(rdata);
	assign kend    = (k_q == KW'(TICKET_SLOTS));
	// read data belongs to the slot addressed in the cycle before
	assign eval_k  = k_q - KW'(1);
	assign below   = (chg_q < CHG_W'(tix));
	assign add_hit = ctl.eval && opsel.add && !rd_slot.used && below;
	assign rem_hit = ctl.eval && opsel.remove && rd_slot.used &&
			(rd_slot.owner == pid) && below;
	assign occ     = ctl.eval && opsel.compact && rd_slot.used;
	assign mov_hit = occ && (eval_k != dst_q);
	assign chg     = chg_q;

	always_comb begin
		we    = 1'b0;
		waddr = k_q[AW-1:0];
		wdata = '0;
		if (ctl.wr_zero && !kend) begin
			we = 1'b1;
		end else if (add_hit) begin
			we          = 1'b1;
			waddr       = eval_k[AW-1:0];
			wdata.used  = 1'b1;
			wdata.owner = pid;
		end else if (rem_hit) begin
			we    = 1'b1;
			waddr = eval_k[AW-1:0];
		end else if (mov_hit) begin
			// source slot is cleared later by the tail sweep
			we    = 1'b1;
			waddr = dst_q[AW-1:0];
			wdata = rd_slot;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q   <= '0;
			dst_q <= '0;
			chg_q <= '0;
		end else begin
			if (ctl.k_zero) begin
				k_q <= '0;
			end else if (ctl.k_dst) begin
				k_q <= dst_q;
			end else if (ctl.rd || (ctl.wr_zero && !kend)) begin
				k_q <= k_q + KW'(1);
			end

			if (ctl.cnt_clr) begin
				dst_q <= '0;
			end else if (occ) begin
				dst_q <= dst_q + KW'(1);
			end

			if (ctl.cnt_clr) begin
				chg_q <= '0;
			end else if (add_hit || rem_hit || (mov_hit && chg_q != CHG_MAX)) begin
				chg_q <= chg_q + CHG_W'(1);
			end
		end
	end

endmodule
`default_nettype wire

FILE: sv/lottery_ticket_table_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lottery_ticket_table_core
// Ticket table of a lottery scheduler: add, remove and compact operations.
// ----------------------------------------------------------------------------
// One command word at a time walks the slot RAM, one slot per cycle, under a
// small microprogram. After reset a clearing pass over every slot runs before
// the first word is taken. Add, remove and compact each scan every slot before
// returning their result; compact then points the scan back at the compact
// pointer and sweeps from there to the end, which empties the tail. A command
// that does nothing (unused code, process out of range) skips the scan and
// goes straight to the result. The result sits in an output register, so the
// block goes back to idle while it waits to be taken.
module lottery_ticket_table_core #(
	parameter int unsigned TICKET_SLOTS = 64
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [15:0] s_tdata,  // func[1:0], proc_id[7:2], prio_class[10:8]
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic      [23:0] m_tdata   // total_tickets[9:0], slots_changed[16:10]
);
	import ltt_pkg::*;

	ctl_t               ctl;
	stat_t              stat;
	opsel_t             opsel;
	logic [FUNC_W-1:0]  func_q;
	logic [PID_W-1:0]   pid_q;
	logic [TIX_W-1:0]   tix_q;
	logic               pid_ok;
	logic               kend;
	logic [CHG_W-1:0]   chg;
	logic [TOTAL_W-1:0] total_q;
	logic [TOTAL_W-1:0] total_nx;
	logic [TOTAL_W:0]   sum;
	logic               out_valid_q;
	logic [TOTAL_W-1:0] out_total_q;
	logic [CHG_W-1:0]   out_chg_q;
	logic               out_free;
	logic               load;

	ltt_sequencer u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.stat   (stat),
		.ctl    (ctl)
	);

	ltt_scan #(
		.TICKET_SLOTS (TICKET_SLOTS)
	) u_scan (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.opsel  (opsel),
		.pid    (pid_q),
		.tix    (tix_q),
		.kend   (kend),
		.chg    (chg)
	);

	assign s_tready = ctl.in_ready;

	assign pid_ok        = (32'(pid_q) < PROCESS_COUNT);
	assign opsel.add     = (func_q == FUNC_ADD) && pid_ok;
	assign opsel.remove  = (func_q == FUNC_REMOVE) && pid_ok;
	assign opsel.compact = (func_q == FUNC_COMPACT);

	assign out_free = !out_valid_q || m_tready;
	assign load     = ctl.load_out && out_free;

	assign stat.in_valid = s_tvalid;
	assign stat.kend     = kend;
	assign stat.skip     = !(opsel.add || opsel.remove || opsel.compact);
	assign stat.nocmp    = !opsel.compact;
	assign stat.out_free = out_free;

	always_comb begin
		sum      = {1'b0, total_q} + (TOTAL_W + 1)'(tix_q);
		total_nx = total_q;
		if (opsel.add) begin
			total_nx = sum[TOTAL_W] ? TOTAL_MAX : sum[TOTAL_W-1:0];
		end else if (opsel.remove) begin
			total_nx = (total_q > TOTAL_W'(tix_q)) ? total_q - TOTAL_W'(tix_q) : '0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			func_q <= s_tdata[1:0];
			pid_q  <= s_tdata[7:2];
			tix_q  <= tickets_of(s_tdata[10:8]);
		end
		if (load) begin
			out_total_q <= total_nx;
			out_chg_q   <= chg;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				total_q     <= total_nx;
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {7'd0, out_chg_q, out_total_q};

endmodule
`default_nettype wire
